@@ rtl/gtc_pkg.sv @@
package gtc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_EXONS_DEF = 64;
  localparam int POS_WIDTH_DEF = 32;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Largest intron distance that still fits a signed 32-bit offset.
  localparam logic [31:0] DIST_LIMIT = 32'h7fff_ffff;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK            = 3'd0,
    STAT_INVALID_ARG   = 3'd1,
    STAT_OUTSIDE       = 3'd2,
    STAT_INVALID_PROJ  = 3'd3,
    STAT_OUT_OF_RANGE  = 3'd4
  } gtc_status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TX_START   = 2'd0,
    CFG_TX_END     = 2'd1,
    CFG_STRAND     = 2'd2,
    CFG_EXON_COUNT = 2'd3
  } gtc_cfg_idx_t;

  // Kind of work a queued command asks of the back end.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_EARLY = 2'd2
  } gtc_kind_t;

  // One queued command. A load carries the four table words in w0..w3;
  // a query carries its masked position in w0.
  typedef struct packed {
    gtc_kind_t   kind;
    gtc_status_t status;
    logic [5:0]  slot;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } gtc_cmd_t;

  // Configuration the back end needs.
  typedef struct packed {
    logic       rev;
    logic [6:0] cnt;
  } gtc_cfg_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_SCAN = 3'd1,
    BK_DIST = 3'd2,
    BK_PICK = 3'd3,
    BK_EMIT = 3'd4
  } gtc_state_t;

endpackage

@@ rtl/gtc_front.sv @@
module gtc_front #(
  parameter int MAX_EXONS = gtc_pkg::MAX_EXONS_DEF,
  parameter int POS_WIDTH = gtc_pkg::POS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [5:0]        in_exon_slot,
  input  logic [31:0]       in_exon_first_base,
  input  logic [31:0]       in_exon_last_base,
  input  logic [31:0]       in_exon_cdna_first,
  input  logic [31:0]       in_exon_cdna_last,
  input  logic [31:0]       in_query_pos,
  input  logic              q_full,
  output logic              cmd_push,
  output gtc_pkg::gtc_cmd_t cmd,
  output gtc_pkg::gtc_cfg_t cfg
);
  import gtc_pkg::*;

  logic [POS_WIDTH-1:0] ts_r;
  logic [POS_WIDTH-1:0] te_r;
  logic                 rev_r;
  logic [6:0]           cnt_r;

  logic                 accept;
  logic [POS_WIDTH-1:0] pos_m;
  logic                 model_bad;
  logic                 slot_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= '0;
      te_r  <= '0;
      rev_r <= 1'b0;
      cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TX_START:   ts_r  <= cfg_wdata[POS_WIDTH-1:0];
        CFG_TX_END:     te_r  <= cfg_wdata[POS_WIDTH-1:0];
        CFG_STRAND:     rev_r <= cfg_wdata[0];
        CFG_EXON_COUNT: cnt_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cfg.rev = rev_r;
  assign cfg.cnt = cnt_r;

  // The front takes an item whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign pos_m     = in_query_pos[POS_WIDTH-1:0];
  assign model_bad = (cnt_r == 7'd0) || (32'(cnt_r) > 32'(MAX_EXONS)) ||
                     (ts_r == '0) || (te_r < ts_r);
  assign slot_ok   = 32'(in_exon_slot) < 32'(MAX_EXONS);

  // Classify the item: table load, early error, or a query that needs a scan.
  always_comb begin
    cmd.slot   = in_exon_slot;
    cmd.status = STAT_OK;
    if (!in_action) begin
      cmd.kind = CMD_LOAD;
      cmd.w0   = 32'(in_exon_first_base[POS_WIDTH-1:0]);
      cmd.w1   = 32'(in_exon_last_base[POS_WIDTH-1:0]);
      cmd.w2   = in_exon_cdna_first;
      cmd.w3   = in_exon_cdna_last;
      cmd_push = accept && slot_ok;
    end else begin
      cmd.w0   = 32'(pos_m);
      cmd.w1   = '0;
      cmd.w2   = '0;
      cmd.w3   = '0;
      cmd_push = accept;
      if (model_bad || (pos_m == '0)) begin
        cmd.kind   = CMD_EARLY;
        cmd.status = STAT_INVALID_ARG;
      end else if ((pos_m < ts_r) || (pos_m > te_r)) begin
        cmd.kind   = CMD_EARLY;
        cmd.status = STAT_OUTSIDE;
      end else begin
        cmd.kind = CMD_SCAN;
      end
    end
  end

endmodule

@@ rtl/gtc_fifo.sv @@
module gtc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gtc_pkg::gtc_cmd_t wr_data,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output gtc_pkg::gtc_cmd_t rd_data
);
  import gtc_pkg::*;

  gtc_cmd_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/gtc_back.sv @@
module gtc_back #(
  parameter int MAX_EXONS = gtc_pkg::MAX_EXONS_DEF,
  parameter int POS_WIDTH = gtc_pkg::POS_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gtc_pkg::gtc_cfg_t  cfg,
  input  logic               q_valid,
  input  gtc_pkg::gtc_cmd_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_exonic,
  output logic [5:0]         out_anchor_exon,
  output logic [31:0]        out_cdna_anchor,
  output logic signed [31:0] out_intron_dist
);
  import gtc_pkg::*;

  localparam int IDX_W = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = 2 * POS_WIDTH + 64;

  // Exon table: {genomic start, genomic end, cDNA start, cDNA end}.
  logic [ENT_W-1:0]     mem [MAX_EXONS];
  logic [ENT_W-1:0]     rd_q;
  logic                 mem_we;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;

  gtc_state_t           state_r;
  gtc_state_t           state_nxt;

  logic [POS_WIDTH-1:0] pos_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic [CNT_W-1:0]     n_cnt;
  logic                 issue_done;
  logic                 scan_start;
  logic                 early;
  logic                 out_free;
  logic                 emit;

  // Read stage.
  logic                 p1_v_r;
  logic [IDX_W-1:0]     p1_idx_r;

  // Compare stage.
  logic [POS_WIDTH-1:0] rs;
  logic [POS_WIDTH-1:0] re;
  logic [31:0]          rcs;
  logic [31:0]          rce;
  logic                 p2_v_r;
  logic [IDX_W-1:0]     p2_idx_r;
  logic [POS_WIDTH-1:0] b_s_r;
  logic [POS_WIDTH-1:0] b_e_r;
  logic [31:0]          b_cs_r;
  logic [31:0]          b_ce_r;
  logic                 b_in_r;
  logic [POS_WIDTH-1:0] b_d_r;
  logic                 b_lo_r;
  logic                 b_hi_r;

  // Update stage.
  logic [32:0]          c_sum;
  logic                 ex_hit;
  logic                 lo_take;
  logic                 hi_take;

  // Scan results.
  logic                 found_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic [31:0]          found_c_r;
  logic                 have_lo_r;
  logic [IDX_W-1:0]     lo_idx_r;
  logic [POS_WIDTH-1:0] lo_end_r;
  logic [31:0]          lo_cs_r;
  logic [31:0]          lo_ce_r;
  logic                 have_hi_r;
  logic [IDX_W-1:0]     hi_idx_r;
  logic [POS_WIDTH-1:0] hi_start_r;
  logic [31:0]          hi_cs_r;
  logic [31:0]          hi_ce_r;

  logic [POS_WIDTH-1:0] dlo_r;
  logic [POS_WIDTH-1:0] dhi_r;

  // Decision.
  logic [31:0]          dlo32;
  logic [31:0]          dhi32;
  logic                 take_lo;
  gtc_status_t          pk_status;
  logic                 pk_exonic;
  logic [5:0]           pk_idx;
  logic [31:0]          pk_anchor;
  logic [31:0]          pk_off;

  gtc_status_t          res_status_r;
  logic                 res_exonic_r;
  logic [5:0]           res_idx_r;
  logic [31:0]          res_anchor_r;
  logic [31:0]          res_off_r;

  gtc_status_t          out_status_r;
  logic                 out_valid_r;
  logic                 out_exonic_r;
  logic [5:0]           out_idx_r;
  logic [31:0]          out_anchor_r;
  logic [31:0]          out_off_r;

  assign n_cnt      = CNT_W'(cfg.cnt);
  assign issue_done = (rd_cnt_r == n_cnt);
  assign out_free   = !out_valid_r || !out_stall;

  // Table write and registered read.
  assign mem_waddr = IDX_W'(q_data.slot);
  assign mem_wdata = {q_data.w0[POS_WIDTH-1:0], q_data.w1[POS_WIDTH-1:0],
                      q_data.w2, q_data.w3};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[rd_cnt_r[IDX_W-1:0]];
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            CMD_SCAN:  state_nxt = BK_SCAN;
            CMD_EARLY: state_nxt = BK_EMIT;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_SCAN: begin
        if (issue_done && !p1_v_r && !p2_v_r) begin
          state_nxt = BK_DIST;
        end
      end
      BK_DIST: state_nxt = BK_PICK;
      BK_PICK: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop      = (state_r == BK_IDLE) && q_valid;
    mem_we     = q_pop && (q_data.kind == CMD_LOAD);
    scan_start = q_pop && (q_data.kind == CMD_SCAN);
    early      = q_pop && (q_data.kind == CMD_EARLY);
    mem_re     = (state_r == BK_SCAN) && !issue_done;
    emit       = (state_r == BK_EMIT) && out_free;
  end

  // Read counter and read-stage tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
    end else begin
      if (scan_start) begin
        rd_cnt_r <= '0;
      end else if (mem_re) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      p1_v_r <= mem_re;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= rd_cnt_r[IDX_W-1:0];
    p2_idx_r <= p1_idx_r;
    if (scan_start) begin
      pos_r <= q_data.w0[POS_WIDTH-1:0];
    end
  end

  // Compare stage: containment, flank candidacy and offset into the exon.
  assign rs  = rd_q[ENT_W-1 -: POS_WIDTH];
  assign re  = rd_q[ENT_W-POS_WIDTH-1 -: POS_WIDTH];
  assign rcs = rd_q[63:32];
  assign rce = rd_q[31:0];

  always_ff @(posedge clk) begin
    b_s_r  <= rs;
    b_e_r  <= re;
    b_cs_r <= rcs;
    b_ce_r <= rce;
    b_in_r <= (pos_r >= rs) && (pos_r <= re) && (rcs != 32'd0) && (rce >= rcs);
    b_d_r  <= cfg.rev ? (re - pos_r) : (pos_r - rs);
    b_lo_r <= re < pos_r;
    b_hi_r <= rs > pos_r;
  end

  // Update stage: first valid containing exon, nearest flank on each side.
  assign c_sum   = {1'b0, b_cs_r} + 33'(b_d_r);
  assign ex_hit  = p2_v_r && b_in_r && (c_sum <= {1'b0, b_ce_r});
  assign lo_take = p2_v_r && b_lo_r && (!have_lo_r || (b_e_r > lo_end_r));
  assign hi_take = p2_v_r && b_hi_r && (!have_hi_r || (b_s_r < hi_start_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      have_lo_r <= 1'b0;
      have_hi_r <= 1'b0;
    end else if (scan_start) begin
      found_r   <= 1'b0;
      have_lo_r <= 1'b0;
      have_hi_r <= 1'b0;
    end else begin
      if (ex_hit) begin
        found_r <= 1'b1;
      end
      if (lo_take) begin
        have_lo_r <= 1'b1;
      end
      if (hi_take) begin
        have_hi_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_hit && !found_r) begin
      found_idx_r <= p2_idx_r;
      found_c_r   <= c_sum[31:0];
    end
    if (lo_take) begin
      lo_idx_r <= p2_idx_r;
      lo_end_r <= b_e_r;
      lo_cs_r  <= b_cs_r;
      lo_ce_r  <= b_ce_r;
    end
    if (hi_take) begin
      hi_idx_r   <= p2_idx_r;
      hi_start_r <= b_s_r;
      hi_cs_r    <= b_cs_r;
      hi_ce_r    <= b_ce_r;
    end
  end

  // Distances to both flanks; settled once the scan has drained.
  always_ff @(posedge clk) begin
    dlo_r <= pos_r - lo_end_r;
    dhi_r <= hi_start_r - pos_r;
  end

  // Final decision for a scanned query.
  assign dlo32   = 32'(dlo_r);
  assign dhi32   = 32'(dhi_r);
  assign take_lo = (dlo_r < dhi_r) || ((dlo_r == dhi_r) && !cfg.rev);

  always_comb begin
    pk_status = STAT_OK;
    pk_exonic = 1'b0;
    pk_idx    = '0;
    pk_anchor = '0;
    pk_off    = '0;
    if (found_r) begin
      pk_exonic = 1'b1;
      pk_idx    = 6'(found_idx_r);
      pk_anchor = found_c_r;
    end else if (!have_lo_r || !have_hi_r) begin
      pk_status = STAT_INVALID_PROJ;
    end else if ((dlo32 > DIST_LIMIT) || (dhi32 > DIST_LIMIT)) begin
      pk_status = STAT_OUT_OF_RANGE;
    end else begin
      if (take_lo) begin
        pk_idx    = 6'(lo_idx_r);
        pk_anchor = cfg.rev ? lo_cs_r : lo_ce_r;
        pk_off    = cfg.rev ? (32'd0 - dlo32) : dlo32;
      end else begin
        pk_idx    = 6'(hi_idx_r);
        pk_anchor = cfg.rev ? hi_ce_r : hi_cs_r;
        pk_off    = cfg.rev ? dhi32 : (32'd0 - dhi32);
      end
      if (pk_anchor == 32'd0) begin
        pk_status = STAT_INVALID_PROJ;
        pk_idx    = '0;
        pk_anchor = '0;
        pk_off    = '0;
      end
    end
  end

  // Result waiting for the output register.
  always_ff @(posedge clk) begin
    if (early) begin
      res_status_r <= q_data.status;
      res_exonic_r <= 1'b0;
      res_idx_r    <= '0;
      res_anchor_r <= '0;
      res_off_r    <= '0;
    end else if (state_r == BK_PICK) begin
      res_status_r <= pk_status;
      res_exonic_r <= pk_exonic;
      res_idx_r    <= pk_idx;
      res_anchor_r <= pk_anchor;
      res_off_r    <= pk_off;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= res_status_r;
      out_exonic_r <= res_exonic_r;
      out_idx_r    <= res_idx_r;
      out_anchor_r <= res_anchor_r;
      out_off_r    <= res_off_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_exonic      = out_exonic_r;
  assign out_anchor_exon = out_idx_r;
  assign out_cdna_anchor = out_anchor_r;
  assign out_intron_dist = $signed(out_off_r);

endmodule

@@ rtl/genomic_to_transcript_coordinate.sv @@
// Projects genomic positions onto one transcript held in an internal exon
// table. An item with action 0 loads one exon slot; an item with action 1
// projects query_pos and gives exactly one result, while loads give none.
// Items enter a two-deep queue and are carried out in order. In the back end
// a load writes its slot; a query with a bad model or an off-transcript
// position goes straight to the result; a query that scans walks every exon
// in use once through the exon table's single read port. The table has no
// reset: every slot below exon_count_used must be loaded before a query.
// Write configuration only while no item is in flight.
module genomic_to_transcript_coordinate #(
  parameter int MAX_EXONS = gtc_pkg::MAX_EXONS_DEF,
  parameter int POS_WIDTH = gtc_pkg::POS_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [5:0]         in_exon_slot,
  input  logic [31:0]        in_exon_first_base,
  input  logic [31:0]        in_exon_last_base,
  input  logic [31:0]        in_exon_cdna_first,
  input  logic [31:0]        in_exon_cdna_last,
  input  logic [31:0]        in_query_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_exonic,
  output logic [5:0]         out_anchor_exon,
  output logic [31:0]        out_cdna_anchor,
  output logic signed [31:0] out_intron_dist
);
  import gtc_pkg::*;

  gtc_cmd_t cmd;
  gtc_cmd_t q_data;
  gtc_cfg_t cfg;
  logic     cmd_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  // Front end: configuration and item classification.
  gtc_front #(
    .MAX_EXONS(MAX_EXONS),
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_exon_slot      (in_exon_slot),
    .in_exon_first_base(in_exon_first_base),
    .in_exon_last_base (in_exon_last_base),
    .in_exon_cdna_first(in_exon_cdna_first),
    .in_exon_cdna_last (in_exon_cdna_last),
    .in_query_pos      (in_query_pos),
    .q_full            (q_full),
    .cmd_push          (cmd_push),
    .cmd               (cmd),
    .cfg               (cfg)
  );

  // Command queue between the two halves.
  gtc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd),
    .full    (q_full),
    .pop     (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_data)
  );

  // Back end: exon table, scan and result register.
  gtc_back #(
    .MAX_EXONS(MAX_EXONS),
    .POS_WIDTH(POS_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_exonic     (out_exonic),
    .out_anchor_exon(out_anchor_exon),
    .out_cdna_anchor(out_cdna_anchor),
    .out_intron_dist(out_intron_dist)
  );

endmodule

@@ test/tb_genomic_to_transcript_coordinate.sv @@
module tb_genomic_to_transcript_coordinate;
  timeunit 1ns;
  timeprecision 1ps;

  import gtc_pkg::*;

  localparam int EXON_SLOTS = MAX_EXONS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEM_TARGET = 1520;
  localparam int PRINT_CAP = 40;

  // Item actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PROJECT = 1'b1;

  // One input item as it goes on the wire.
  typedef struct {
    logic        action;
    logic [5:0]  slot;
    logic [31:0] gfirst;
    logic [31:0] glast;
    logic [31:0] cfirst;
    logic [31:0] clast;
    logic [31:0] qpos;
  } coord_item_t;

  // One projected coordinate.
  typedef struct packed {
    gtc_status_t status;
    logic        exonic;
    logic [5:0]  exon;
    logic [31:0] cdna;
    logic [31:0] offset;
  } tx_coord_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [5:0]  in_exon_slot = '0;
  logic [31:0] in_exon_first_base = '0;
  logic [31:0] in_exon_last_base = '0;
  logic [31:0] in_exon_cdna_first = '0;
  logic [31:0] in_exon_cdna_last = '0;
  logic [31:0] in_query_pos = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic        out_exonic;
  logic [5:0]  out_anchor_exon;
  logic [31:0] out_cdna_anchor;
  logic signed [31:0] out_intron_dist;

  // Shadow copy of the configuration and the exon table.
  logic [31:0] tx_start_m = '0;
  logic [31:0] tx_end_m = '0;
  logic        rev_m = 1'b0;
  logic [6:0]  cnt_m = '0;
  logic [31:0] gstart_m [EXON_SLOTS];
  logic [31:0] gend_m [EXON_SLOTS];
  logic [31:0] cstart_m [EXON_SLOTS];
  logic [31:0] cend_m [EXON_SLOTS];

  coord_item_t pending_items[$];
  tx_coord_t   expected_coords[$];
  coord_item_t drv_item;
  tx_coord_t   mon_want;
  int          pushed_cnt = 0;
  int          accepted_cnt = 0;
  int          results_seen = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  logic        calm = 1'b0;

  genomic_to_transcript_coordinate i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_exon_slot       (in_exon_slot),
    .in_exon_first_base (in_exon_first_base),
    .in_exon_last_base  (in_exon_last_base),
    .in_exon_cdna_first (in_exon_cdna_first),
    .in_exon_cdna_last  (in_exon_cdna_last),
    .in_query_pos       (in_query_pos),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_exonic         (out_exonic),
    .out_anchor_exon    (out_anchor_exon),
    .out_cdna_anchor    (out_cdna_anchor),
    .out_intron_dist    (out_intron_dist)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Projects one genomic position onto the shadow transcript.
  function automatic tx_coord_t project_position(input logic [31:0] pos);
    tx_coord_t   r;
    logic        have_lo;
    logic        have_hi;
    logic        take_lo;
    logic [5:0]  lo_idx;
    logic [5:0]  hi_idx;
    logic [5:0]  idx;
    logic [31:0] lo_end;
    logic [31:0] hi_start;
    logic [31:0] dlo;
    logic [31:0] dhi;
    logic [31:0] anchor;
    logic [31:0] off;
    logic [32:0] c;
    r = '0;
    have_lo = 1'b0;
    have_hi = 1'b0;
    lo_idx = '0;
    hi_idx = '0;
    lo_end = '0;
    hi_start = '0;
    if (cnt_m == 0 || cnt_m > EXON_SLOTS || tx_start_m == 0 || tx_end_m < tx_start_m ||
        pos == 0) begin
      r.status = STAT_INVALID_ARG;
      return r;
    end
    if (pos < tx_start_m || pos > tx_end_m) begin
      r.status = STAT_OUTSIDE;
      return r;
    end
    // The first containing exon with a sane cDNA span wins.
    for (int i = 0; i < cnt_m; i++) begin
      if (pos >= gstart_m[i] && pos <= gend_m[i] && cstart_m[i] != 0 &&
          cend_m[i] >= cstart_m[i]) begin
        if (rev_m) c = {1'b0, cstart_m[i]} + {1'b0, 32'(gend_m[i] - pos)};
        else c = {1'b0, cstart_m[i]} + {1'b0, 32'(pos - gstart_m[i])};
        if (c <= {1'b0, cend_m[i]}) begin
          r.exonic = 1'b1;
          r.exon = 6'(i);
          r.cdna = c[31:0];
          return r;
        end
      end
    end
    // Intronic: find the nearest exon on each side, lowest slot on a tie.
    for (int i = 0; i < cnt_m; i++) begin
      if (gend_m[i] < pos && (!have_lo || gend_m[i] > lo_end)) begin
        have_lo = 1'b1;
        lo_idx = 6'(i);
        lo_end = gend_m[i];
      end
      if (gstart_m[i] > pos && (!have_hi || gstart_m[i] < hi_start)) begin
        have_hi = 1'b1;
        hi_idx = 6'(i);
        hi_start = gstart_m[i];
      end
    end
    if (!have_lo || !have_hi) begin
      r.status = STAT_INVALID_PROJ;
      return r;
    end
    dlo = pos - lo_end;
    dhi = hi_start - pos;
    if (dlo > DIST_LIMIT || dhi > DIST_LIMIT) begin
      r.status = STAT_OUT_OF_RANGE;
      return r;
    end
    take_lo = (dlo < dhi) || (dlo == dhi && !rev_m);
    if (take_lo) begin
      idx = lo_idx;
      anchor = rev_m ? cstart_m[idx] : cend_m[idx];
      off = rev_m ? 32'(0 - dlo) : dlo;
    end else begin
      idx = hi_idx;
      anchor = rev_m ? cend_m[idx] : cstart_m[idx];
      off = rev_m ? dhi : 32'(0 - dhi);
    end
    if (anchor == 0) begin
      r.status = STAT_INVALID_PROJ;
      return r;
    end
    r.exon = idx;
    r.cdna = anchor;
    r.offset = off;
    return r;
  endfunction

  // An accepted load updates the table; an accepted query expects a result.
  task automatic track_item(input coord_item_t it);
    if (it.action == ACT_LOAD) begin
      gstart_m[it.slot] = it.gfirst;
      gend_m[it.slot] = it.glast;
      cstart_m[it.slot] = it.cfirst;
      cend_m[it.slot] = it.clast;
    end else begin
      expected_coords.push_back(project_position(it.qpos));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got, want);
  endtask

  // Input driver: holds a stalled item, otherwise idles or sends the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_item(drv_item);
        accepted_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
          drv_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_action <= drv_item.action;
          in_exon_slot <= drv_item.slot;
          in_exon_first_base <= drv_item.gfirst;
          in_exon_last_base <= drv_item.glast;
          in_exon_cdna_first <= drv_item.cfirst;
          in_exon_cdna_last <= drv_item.clast;
          in_query_pos <= drv_item.qpos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_coords.size() == 0) begin
          report_mismatch("status with no expectation", 32'(out_status), '0);
        end else begin
          mon_want = expected_coords.pop_front();
          if (out_status !== mon_want.status)
            report_mismatch("status", 32'(out_status), 32'(mon_want.status));
          if (out_exonic !== mon_want.exonic)
            report_mismatch("exonic", 32'(out_exonic), 32'(mon_want.exonic));
          if (out_anchor_exon !== mon_want.exon)
            report_mismatch("anchor_exon", 32'(out_anchor_exon), 32'(mon_want.exon));
          if (out_cdna_anchor !== mon_want.cdna)
            report_mismatch("cdna_anchor", out_cdna_anchor, mon_want.cdna);
          if (out_intron_dist !== mon_want.offset)
            report_mismatch("intron distance", out_intron_dist, mon_want.offset);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 19);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_load(input logic [5:0] slot, input logic [31:0] s, input logic [31:0] e,
                           input logic [31:0] cs, input logic [31:0] ce);
    coord_item_t it;
    it.action = ACT_LOAD;
    it.slot = slot;
    it.gfirst = s;
    it.glast = e;
    it.cfirst = cs;
    it.clast = ce;
    it.qpos = $urandom;
    pending_items.push_back(it);
    pushed_cnt++;
  endtask

  task automatic push_query(input logic [31:0] pos);
    coord_item_t it;
    it.action = ACT_PROJECT;
    it.slot = 6'($urandom);
    it.gfirst = $urandom;
    it.glast = $urandom;
    it.cfirst = $urandom;
    it.clast = $urandom;
    it.qpos = pos;
    pending_items.push_back(it);
    pushed_cnt++;
  endtask

  task automatic write_reg(input gtc_cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TX_START:   tx_start_m = val;
      CFG_TX_END:     tx_end_m = val;
      CFG_STRAND:     rev_m = val[0];
      CFG_EXON_COUNT: cnt_m = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] txs, input logic [31:0] txe, input logic rev,
                            input logic [6:0] cnt);
    write_reg(CFG_TX_START, txs);
    write_reg(CFG_TX_END, txe);
    write_reg(CFG_STRAND, {31'b0, rev});
    write_reg(CFG_EXON_COUNT, {25'b0, cnt});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every item is in and every result out, then lets loads settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_cnt != pushed_cnt || expected_coords.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: a fresh transcript, its loads, then a batch of queries.
  task automatic random_phase();
    int          n;
    int          nq;
    int          g;
    int          slot;
    int          len;
    int          gap;
    int          far_k;
    logic        rev;
    logic [31:0] cur;
    logic [31:0] cdn;
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] cs;
    logic [31:0] ce;
    logic [31:0] txs;
    logic [31:0] txe;
    logic [31:0] q;
    logic [31:0] gs [EXON_SLOTS];
    logic [31:0] ge [EXON_SLOTS];
    rev = 1'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      // Broken model: every query must come back as a bad argument.
      case ($urandom_range(0, 3))
        0: set_config($urandom, $urandom, rev, 7'd0);
        1: set_config($urandom, $urandom, rev, 7'($urandom_range(65, 127)));
        2: set_config('0, $urandom, rev, 7'($urandom_range(1, 64)));
        default: begin
          txs = $urandom | 32'h8000_0000;
          txe = txs - 32'd1 - ($urandom & 32'h7fff_ffff);
          set_config(txs, txe, rev, 7'($urandom_range(1, 64)));
        end
      endcase
      nq = $urandom_range(3, 8);
      for (int k = 0; k < nq; k++) push_query($urandom_range(0, 3) == 0 ? '0 : $urandom);
    end else begin
      // Mostly short transcripts, now and then a full table.
      case ($urandom_range(0, 19))
        0, 1:    n = EXON_SLOTS;
        2:       n = $urandom_range(9, EXON_SLOTS - 1);
        default: n = $urandom_range(1, 8);
      endcase
      far_k = (n <= 8 && $urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
      cur = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'hfff0_0000)
                                        : $urandom_range(1, 5000);
      if (far_k >= 0) cur = $urandom_range(1, 5000);
      for (int k = 0; k < n; k++) begin
        len = $urandom_range(1, 40);
        gs[k] = cur;
        ge[k] = cur + len - 1;
        gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60);
        if (k == far_k) gap = 32'h7fff_fff0 + $urandom_range(0, 40);
        cur = ge[k] + 1 + gap;
      end
      txs = (gs[0] > 2 && $urandom_range(0, 1) == 1) ? gs[0] - $urandom_range(1, 2) : gs[0];
      txe = ($urandom_range(0, 9) == 0) ? 32'hffff_ffff : ge[n-1] + $urandom_range(0, 2);
      set_config(txs, txe, rev, 7'(n));
      // Slots follow transcript order: upstream first on either strand.
      cdn = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 3);
      for (slot = 0; slot < n; slot++) begin
        g = rev ? n - 1 - slot : slot;
        s = gs[g];
        e = ge[g];
        cs = cdn;
        ce = cdn + (e - s);
        cdn = ce + 1;
        case ($urandom_range(0, 19))
          0: cs = '0;
          1: ce = cs - 1;
          2: ce = ce - 1;
          3: ce = '0;
          4: begin
            g = $urandom_range(0, n - 1);
            s = gs[g];
            e = ge[g];
          end
          5: begin
            s = $urandom;
            e = $urandom;
            cs = $urandom;
            ce = $urandom;
          end
          default: ;
        endcase
        if ($urandom_range(0, 29) == 0)
          push_load(6'(slot), $urandom, $urandom, $urandom, $urandom);
        push_load(6'(slot), s, e, cs, ce);
      end
      if (n < EXON_SLOTS && $urandom_range(0, 3) == 0)
        push_load(6'($urandom_range(n, EXON_SLOTS - 1)), $urandom, $urandom, $urandom,
                  $urandom);
      // Queries aimed at exon edges, intron middles and the transcript ends.
      nq = $urandom_range(8, 30);
      for (int k = 0; k < nq; k++) begin
        g = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
          0: q = gs[g];
          1: q = ge[g];
          2: q = gs[g] - 1;
          3: q = ge[g] + 1;
          4: q = (g < n - 1) ? ge[g] + ((gs[g+1] - ge[g]) >> 1) + $urandom_range(0, 1)
                             : gs[g];
          5: q = gs[g] + $urandom_range(0, ge[g] - gs[g]);
          6: q = $urandom_range(txs, txe);
          7: begin
            case ($urandom_range(0, 3))
              0: q = txs - 1;
              1: q = txe + 1;
              2: q = '0;
              default: q = 32'hffff_ffff;
            endcase
          end
          8: q = $urandom;
          default: q = (g < n - 1 && gs[g+1] > ge[g] + 1)
                       ? $urandom_range(ge[g] + 1, gs[g+1] - 1) : ge[g];
        endcase
        push_query(q);
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    int phase_no;
    phase_no = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset: no exons in use, so any query is a bad argument.
    push_query('0);
    push_query(32'd5);
    wait_idle();

    // Forward strand with a broken exon whose cDNA end is zero.
    set_config(32'd100, 32'hffff_ffff, 1'b0, 7'd4);
    push_load(6'd0, 32'd100, 32'd199, 32'd1, 32'd100);
    push_load(6'd1, 32'd301, 32'd400, 32'd101, 32'd200);
    push_load(6'd2, 32'd500, 32'd509, 32'd300, 32'd0);
    push_load(6'd3, 32'd600, 32'd699, 32'd201, 32'd300);
    push_load(6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_query(32'd100);
    push_query(32'd199);
    push_query(32'd250);
    push_query(32'd260);
    push_query(32'd99);
    push_query(32'd505);
    push_query(32'd520);
    push_query(32'd50000);
    push_query(32'hffff_ffff);
    wait_idle();

    // Reverse strand with an exon far beyond the last intron.
    set_config(32'd1, 32'hffff_ffff, 1'b1, 7'd5);
    push_load(6'd4, 32'hf000_0000, 32'hf000_0009, 32'd301, 32'd310);
    push_query(32'd250);
    push_query(32'd800);
    push_query(32'hf000_0005);
    push_query(32'd150);
    push_query('0);
    wait_idle();

    // Exon count past the table size.
    set_config(32'd1, 32'hffff_ffff, 1'b0, 7'd127);
    push_query(32'd150);
    wait_idle();

    while (pushed_cnt < ITEM_TARGET) begin
      calm = (phase_no >= 6 && phase_no < 10);
      random_phase();
      wait_idle();
      phase_no++;
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
